>>> sv/serial_line_editor_core_defines.svh
// Assertion macros shared by the serial line editor RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SERIAL_LINE_EDITOR_CORE_DEFINES_SVH
`define SERIAL_LINE_EDITOR_CORE_DEFINES_SVH

// Checked on every rising edge of clk_i, switched off while rst_ni is low.
`define SLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, during reset as well.
`define SLE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/sle_pkg.sv
// Types and constants for the serial line editor.
// No dependencies; imported by serial_line_editor_core.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  localparam int unsigned LineCap = 32;
  localparam int unsigned AddrW   = $clog2(LineCap);
  localparam int unsigned FillW   = 6;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CharW-1:0] SpaceChar     = 8'h20;
  localparam logic [CharW-1:0] BackspaceRst  = 8'h08;
  localparam logic [CharW-1:0] EnterRst      = 8'h0D;

  localparam logic [CfgIdxW-1:0] CfgBackspace = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgEnter     = 8'd1;

  typedef logic [CharW-1:0] char_t;
  typedef logic [FillW-1:0] fill_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ECHO = 4'b0010,
    S_RD   = 4'b0100,
    S_WAIT = 4'b1000
  } state_e;

endpackage

`default_nettype wire

>>> sv/sle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the line store.
`timescale 1ns / 1ps
`default_nettype none

module sle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/serial_line_editor_core.sv
// Serial line editor: echo of received characters and line buffer editing.
// After a character is taken, its first echo is loaded into the output register in
// S_ECHO once that register is free. No new character is taken before all its echoes
// are issued; an enter adds the line, each character a RAM read and its transfer.
// Reset: fill count cleared, backspace code 8, enter code 13; the line RAM is not
// cleared, as only entries already written are ever read. Depends on sle_pkg, sle_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_line_editor_core_defines.svh"

module serial_line_editor_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Received characters.
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire sle_pkg::char_t               rx_char_i,
  // Echo characters and completed lines.
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              dest_o,
  output sle_pkg::char_t                    out_char_o,
  output sle_pkg::fill_t                    line_length_o,
  output logic                              last_o,
  // Register writes.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sle_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire sle_pkg::char_t               cfg_data_i
);

  import sle_pkg::*;

  // Configuration registers. Writes are always taken; an unknown index is dropped.
  char_t bs_code_q, en_code_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_code_q <= BackspaceRst;
      en_code_q <= EnterRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgBackspace: bs_code_q <= cfg_data_i;
        CfgEnter:     en_code_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Sequencer and line state.
  state_e state_q, state_d;
  fill_t  fill_q, fill_d;
  fill_t  line_len_q, line_len_d;
  fill_t  line_idx_q, line_idx_d;
  logic   line_q, line_d;
  char_t  echo_q [4];
  char_t  echo_d [4];
  logic [1:0] echo_last_q, echo_last_d;
  logic [1:0] echo_idx_q, echo_idx_d;

  // Output register, which parts the sequencer from a stalling receiver.
  logic  out_valid_q, out_valid_d;
  logic  out_dest_q, out_dest_d;
  char_t out_char_q, out_char_d;
  fill_t out_len_q, out_len_d;
  logic  out_last_q, out_last_d;

  logic  in_accept;
  logic  out_free;
  logic  is_bs, is_en, is_full;
  fill_t fill_edit;
  logic  ram_we, ram_re;
  char_t ram_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign is_bs   = (rx_char_i == bs_code_q);
  assign is_en   = (rx_char_i == en_code_q);
  assign is_full = (fill_q == FillW'(LineCap));

  // A stored character is written at the fill position when it is taken; the line is
  // only read back after the echoes, so a read never meets a write in flight.
  assign ram_we = in_accept && !is_bs && !is_full;
  assign ram_re = (state_q == S_RD);

  sle_ram #(
    .Width (CharW),
    .Depth (LineCap)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AddrW-1:0]),
    .wdata_i (rx_char_i),
    .re_i    (ram_re),
    .raddr_i (line_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    line_len_d  = line_len_q;
    line_idx_d  = line_idx_q;
    line_d      = line_q;
    echo_d      = echo_q;
    echo_last_d = echo_last_q;
    echo_idx_d  = echo_idx_q;
    fill_edit   = fill_q;

    out_valid_d = out_valid_q && !(out_valid_q && !out_stall_i);
    out_dest_d  = out_dest_q;
    out_char_d  = out_char_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          // Build the echo list: the character itself comes first in every case.
          echo_d[0] = rx_char_i;
          echo_d[1] = SpaceChar;
          echo_d[2] = bs_code_q;
          echo_d[3] = bs_code_q;
          if (is_bs) begin
            if (fill_q != '0) begin
              fill_edit   = fill_q - FillW'(1);
              echo_last_d = 2'd2;
            end else begin
              echo_last_d = 2'd1;
            end
          end else if (!is_full) begin
            fill_edit   = fill_q + FillW'(1);
            echo_last_d = 2'd0;
          end else begin
            // Full line: backspace, space, backspace rubs out the refused character.
            echo_d[1]   = bs_code_q;
            echo_d[2]   = SpaceChar;
            echo_last_d = 2'd3;
          end
          // An enter delivers whatever the edit left, then empties the line.
          line_d     = is_en && (fill_edit != '0);
          line_len_d = fill_edit;
          fill_d     = is_en ? '0 : fill_edit;
          echo_idx_d = 2'd0;
          line_idx_d = '0;
          state_d    = S_ECHO;
        end
      end
      S_ECHO: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dest_d  = 1'b0;
          out_char_d  = echo_q[echo_idx_q];
          out_len_d   = '0;
          out_last_d  = (echo_idx_q == echo_last_q) && !line_q;
          if (echo_idx_q == echo_last_q) begin
            state_d = line_q ? S_RD : S_IDLE;
          end else begin
            echo_idx_d = echo_idx_q + 2'd1;
          end
        end
      end
      S_RD: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dest_d  = 1'b1;
          out_char_d  = ram_rdata;
          out_len_d   = line_len_q;
          out_last_d  = (line_idx_q + FillW'(1) == line_len_q);
          if (line_idx_q + FillW'(1) == line_len_q) begin
            state_d = S_IDLE;
          end else begin
            line_idx_d = line_idx_q + FillW'(1);
            state_d    = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      line_q      <= 1'b0;
      echo_last_q <= 2'd0;
      echo_idx_q  <= 2'd0;
      line_idx_q  <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      line_q      <= line_d;
      echo_last_q <= echo_last_d;
      echo_idx_q  <= echo_idx_d;
      line_idx_q  <= line_idx_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    echo_q     <= echo_d;
    line_len_q <= line_len_d;
    out_dest_q <= out_dest_d;
    out_char_q <= out_char_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign dest_o        = out_dest_q;
  assign out_char_o    = out_char_q;
  assign line_length_o = out_len_q;
  assign last_o        = out_last_q;

  // A final result may still wait in the output register while the next character
  // has been taken, but then its first echo has not yet been issued.
  `SLE_ASSERT_ALWAYS(a_fill_in_range, fill_q <= FillW'(LineCap), "fill count above line capacity")
  `SLE_ASSERT(a_store_counts_up, (in_accept && !is_bs && !is_full && !is_en) |=> (fill_q == FillW'($past(fill_q) + FillW'(1))), "stored character did not advance the fill count")
  `SLE_ASSERT(a_last_ends_item, (out_valid_q && out_last_q) |-> ((state_q == S_IDLE) || ((state_q == S_ECHO) && (echo_idx_q == 2'd0))), "final result waiting while the sequencer is past the next first echo")
  `SLE_ASSERT(a_write_only_idle, ram_we |-> (state_q == S_IDLE), "line RAM written outside the idle state")
  `SLE_ASSERT(a_line_len_sane, (out_valid_q && out_dest_q) |-> ((out_len_q != '0) && (out_len_q <= FillW'(LineCap))), "line result with an impossible length")

endmodule

`default_nettype wire

>>> dv/serial_line_editor_core_test.sv
// Self-checking testbench for serial_line_editor_core: echo rules, line editing and
// delivery of completed lines, under random idle gaps and output stalls.
// Depends on sle_pkg and the serial_line_editor_core RTL only.
`timescale 1ns / 1ps

module serial_line_editor_core_test;
  import sle_pkg::*;

  // Generous bound: even every character stalled at every result stays far below it.
  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 8;
  localparam int MaxPrinted   = 40;

  // Register indexes that the block does not decode.
  localparam logic [CfgIdxW-1:0] CfgSpare = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgTop   = 8'hFF;

  typedef struct packed {
    logic  dest;
    char_t ch;
    fill_t len;
    logic  last;
  } editor_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  char_t               rx_char_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                dest_o;
  char_t               out_char_o;
  fill_t               line_length_o;
  logic                last_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  char_t               cfg_data_i  = '0;

  // Shadow copy of the editor: register values, line buffer and fill count.
  char_t          bs_code    = BackspaceRst;
  char_t          enter_code = EnterRst;
  char_t          line_copy [LineCap];
  fill_t          line_fill  = '0;
  editor_result_t pending_results [$];

  int mismatches   = 0;
  int results_seen = 0;
  int cycles       = 0;
  int chars_sent   = 0;
  int stall_left   = 0;
  bit quiet        = 1'b0;

  serial_line_editor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_char_i     (rx_char_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .dest_o        (dest_o),
    .out_char_o    (out_char_o),
    .line_length_o (line_length_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic editor_result_t make_result(logic dest, char_t ch, fill_t len);
    editor_result_t r;
    r.dest = dest;
    r.ch   = ch;
    r.len  = len;
    r.last = 1'b0;
    return r;
  endfunction

  // Works out every result that one received character causes and queues them.
  task automatic predict_edit(input char_t c);
    editor_result_t batch [$];
    editor_result_t tail;
    batch.push_back(make_result(1'b0, c, '0));
    if (c == bs_code) begin
      if (line_fill != 0) begin
        line_fill--;
        batch.push_back(make_result(1'b0, SpaceChar, '0));
        batch.push_back(make_result(1'b0, bs_code, '0));
      end else begin
        batch.push_back(make_result(1'b0, SpaceChar, '0));
      end
    end else if (line_fill < LineCap) begin
      line_copy[line_fill] = c;
      line_fill++;
    end else begin
      batch.push_back(make_result(1'b0, bs_code, '0));
      batch.push_back(make_result(1'b0, SpaceChar, '0));
      batch.push_back(make_result(1'b0, bs_code, '0));
    end
    if (c == enter_code) begin
      for (int i = 0; i < line_fill; i++) begin
        batch.push_back(make_result(1'b1, line_copy[i], line_fill));
      end
      line_fill = '0;
    end
    tail = batch.pop_back();
    tail.last = 1'b1;
    batch.push_back(tail);
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endtask

  // Offers one character after a random gap and records its results once taken.
  // Valid stays high on return so that a following character can go back to back.
  task automatic send_char(input char_t c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_char_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    predict_edit(c);
    chars_sent++;
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input char_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgBackspace) bs_code = data;
    else if (idx == CfgEnter) enter_code = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic char_t pick_plain_char();
    char_t c;
    do c = char_t'($urandom_range(0, 255)); while (c == bs_code || c == enter_code);
    return c;
  endfunction

  // Output side: after each transfer a new stall is drawn at random, and a stall
  // may also start while nothing is offered.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      stall_left = quiet ? 0 : $urandom_range(0, 8);
    end else if (stall_left == 0 && !quiet && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 8);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin : check_results
    editor_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending (char %02h)",
                                  results_seen, out_char_o));
      end else begin
        want = pending_results.pop_front();
        if (dest_o !== want.dest)
          report_mismatch($sformatf("result %0d: dest %0b, expected %0b",
                                    results_seen, dest_o, want.dest));
        if (out_char_o !== want.ch)
          report_mismatch($sformatf("result %0d: out_char %02h, expected %02h",
                                    results_seen, out_char_o, want.ch));
        if (line_length_o !== want.len)
          report_mismatch($sformatf("result %0d: line_length %0d, expected %0d",
                                    results_seen, line_length_o, want.len));
        if (last_o !== want.last)
          report_mismatch($sformatf("result %0d: last %0b, expected %0b",
                                    results_seen, last_o, want.last));
      end
    end
  end

  // Codes as they come out of reset: erase, backspace on an empty line, enter.
  task automatic test_default_codes();
    send_char(8'h41);
    send_char(BackspaceRst);
    send_char(BackspaceRst);
    send_char(8'h78);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(EnterRst);
    send_char(EnterRst);
    wait_until_drained();
  endtask

  // Writes to undecoded indexes must leave both codes as they were.
  task automatic test_unknown_registers();
    write_register(CfgSpare, char_t'($urandom_range(0, 255)));
    write_register(CfgTop, char_t'($urandom_range(0, 255)));
    send_char(8'h7A);
    send_char(bs_code);
    send_char(8'h6B);
    send_char(enter_code);
    wait_until_drained();
  endtask

  task automatic test_code_extremes();
    write_register(CfgBackspace, 8'h00);
    write_register(CfgEnter, 8'hFF);
    send_char(8'h00);
    send_char(8'h61);
    send_char(8'h00);
    send_char(8'h08);
    send_char(8'hFF);
    wait_until_drained();
    write_register(CfgBackspace, 8'hFF);
    write_register(CfgEnter, 8'h00);
    send_char(8'h62);
    send_char(8'hFF);
    send_char(8'h00);
    wait_until_drained();
  endtask

  // One code for both: it erases first, then whatever is left goes out as the line.
  task automatic test_enter_is_backspace();
    write_register(CfgBackspace, 8'h7F);
    write_register(CfgEnter, 8'h7F);
    send_char(8'h71);
    send_char(8'h7F);
    send_char(8'h7F);
    send_char(8'h72);
    send_char(8'h73);
    send_char(8'h7F);
    wait_until_drained();
  endtask

  // Overflow echo, enter on a full line, and enter taking the last free entry.
  task automatic test_full_line();
    write_register(CfgBackspace, BackspaceRst);
    write_register(CfgEnter, EnterRst);
    repeat (LineCap + 1) send_char(pick_plain_char());
    send_char(enter_code);
    repeat (LineCap - 1) send_char(pick_plain_char());
    send_char(enter_code);
    repeat (LineCap) send_char(pick_plain_char());
    send_char(bs_code);
    send_char(enter_code);
    wait_until_drained();
  endtask

  // Mostly whole lines with random content and the odd erase; some lines run past
  // the capacity, and some characters are arbitrary bytes.
  task automatic test_random_traffic();
    int target;
    int len;
    int pick;
    char_t code;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_register(CfgBackspace, 8'h00);
          write_register(CfgEnter, 8'hFF);
        end
        1: begin
          write_register(CfgBackspace, 8'hFF);
          write_register(CfgEnter, 8'h00);
        end
        2: begin
          code = char_t'($urandom_range(0, 255));
          write_register(CfgBackspace, code);
          write_register(CfgEnter, code);
        end
        default: begin
          write_register(CfgBackspace, char_t'($urandom_range(0, 255)));
          write_register(CfgEnter, char_t'($urandom_range(0, 255)));
        end
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      target = chars_sent + 30;
      while (chars_sent < target) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 12) send_char(bs_code);
          else if (pick < 20) send_char(char_t'($urandom_range(0, 255)));
          else send_char(pick_plain_char());
        end
        send_char(enter_code);
      end
      wait_until_drained();
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_codes();
    test_unknown_registers();
    test_code_extremes();
    test_enter_is_backspace();
    test_full_line();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
